@@ rtl/core/rce_pkg.sv @@
// ----------------------------------------------------------------------------
// rce_pkg
// Shared constants and types for the Roberts cross edge filter.
// ----------------------------------------------------------------------------
package rce_pkg;

  // Geometry defaults and limits
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int WIDTH_RESET    = 640;
  localparam int HEIGHT_RESET   = 480;
  localparam int MIN_DIM        = 2;

  // Field widths
  localparam int PIXEL_W    = 8;
  localparam int EDGE_W     = 8;
  localparam int OUT_ROW_W  = 12;
  localparam int OUT_COL_W  = 11;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_DATA_W = 32;  // edge_res + out_row + out_col = 31, padded

  // Configuration port
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 13;
  localparam int IMG_WIDTH_W  = 12;
  localparam int IMG_HEIGHT_W = 13;

  // Saturation ceiling of the gradient
  localparam logic [EDGE_W-1:0] EDGE_MAX = 8'd255;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1
  } cfg_reg_t;

  // Result kinds of one input pixel, in emission order
  localparam int RES_GRAD     = 0;  // gradient for (y-1, x-1)
  localparam int RES_COL_END  = 1;  // zero for (y-1, W-1)
  localparam int RES_ROW_END  = 2;  // zero for (y, x-1) on the last row
  localparam int RES_FRM_END  = 3;  // zero for (y, W-1), end of frame
  localparam int RES_KINDS    = 4;

  typedef logic [RES_KINDS-1:0] res_mask_t;

endpackage

@@ rtl/core/roberts_cross_edge_filter.sv @@
// ----------------------------------------------------------------------------
// roberts_cross_edge_filter
// Streaming Roberts cross edge detector on 8-bit grey pixels in raster order.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake          Word contents (low bit up)
//  --------  ---  -----------------  ------------------------------------------
//  s_*       in   s_tvalid/s_tready  tdata: pixel[7:0]
//  m_*       out  m_tvalid/m_tready  tdata: edge_res[7:0], out_row[19:8],
//                                    out_col[30:20], zero[31];
//                                    tlast: last; tuser: frame_end
//  cfg_*     in   cfg_valid/cfg_ready index 0 image_width, 1 image_height
//
//  Cycles, while m_tready is high: one pixel per clock while each pixel
//  yields at most one result. A pixel on the last column or last row, save
//  row 0 and column 0, yields two or four results, one per clock from the
//  result stage; the input stalls until the last is issued. The line store
//  is a one-port-each RAM: the column is read and overwritten in the accept
//  cycle; the old value (the pixel above) reaches the result stage next cycle.
//  Reset: synchronous, clears counters, window registers and valid flags;
//  no clearing pass over the line store (row 0 writes it before a read is used).
//  Stalls: m_tready low holds the output word and backs up into s_tready.
//
module roberts_cross_edge_filter #(
  parameter int MAX_WIDTH  = rce_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rce_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Pixel input
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rce_pkg::IN_TDATA_W-1:0]  s_tdata,   // pixel[7:0]
  // Result output
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rce_pkg::OUT_DATA_W-1:0]  m_tdata,   // edge_res, out_row, out_col
  output logic                            m_tlast,
  output logic                            m_tuser,   // frame_end
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rce_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rce_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int W_RST = (rce_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : rce_pkg::WIDTH_RESET;
  localparam int H_RST = (rce_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                              : rce_pkg::HEIGHT_RESET;
  localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(W_RST - 1);
  localparam logic [ROW_W-1:0] H_LAST_RST = ROW_W'(H_RST - 1);
  localparam logic [COL_W-1:0] W_LAST_MAX = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] H_LAST_MAX = ROW_W'(MAX_HEIGHT - 1);
  localparam logic [COL_W-1:0] W_LAST_MIN = COL_W'(rce_pkg::MIN_DIM - 1);
  localparam logic [ROW_W-1:0] H_LAST_MIN = ROW_W'(rce_pkg::MIN_DIM - 1);

  // --------------------------------------------------------------------------
  // Configuration: keep the clamped last column and last row indexes
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;
  logic [COL_W-1:0] w_last_next;
  logic [ROW_W-1:0] h_last_next;
  logic [rce_pkg::IMG_WIDTH_W-1:0]  cfg_width;
  logic [rce_pkg::IMG_HEIGHT_W-1:0] cfg_height;
  logic cfg_write;
  logic cfg_hit;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign cfg_width  = cfg_data[rce_pkg::IMG_WIDTH_W-1:0];
  assign cfg_height = cfg_data[rce_pkg::IMG_HEIGHT_W-1:0];
  assign cfg_hit    = (cfg_index == rce_pkg::REG_IMAGE_WIDTH) ||
                      (cfg_index == rce_pkg::REG_IMAGE_HEIGHT);

  // Clamp to MIN_DIM..MAX, store value minus one
  always_comb begin
    if (32'(cfg_width) < rce_pkg::MIN_DIM) begin
      w_last_next = W_LAST_MIN;
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      w_last_next = W_LAST_MAX;
    end else begin
      w_last_next = COL_W'(32'(cfg_width) - 1);
    end
    if (32'(cfg_height) < rce_pkg::MIN_DIM) begin
      h_last_next = H_LAST_MIN;
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      h_last_next = H_LAST_MAX;
    end else begin
      h_last_next = ROW_W'(32'(cfg_height) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last <= W_LAST_RST;
      h_last <= H_LAST_RST;
    end else if (cfg_write) begin
      if (cfg_index == rce_pkg::REG_IMAGE_WIDTH) begin
        w_last <= w_last_next;
      end
      if (cfg_index == rce_pkg::REG_IMAGE_HEIGHT) begin
        h_last <= h_last_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Accept stage: raster counters, line store access, result flags
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic             in_fire;
  logic [rce_pkg::PIXEL_W-1:0] pixel;
  logic             col_is_last;
  logic             row_is_last;
  logic             col_nz;
  logic             row_nz;
  rce_pkg::res_mask_t in_mask;
  logic [rce_pkg::PIXEL_W-1:0] above;   // line store word, valid in result stage

  assign in_fire     = s_tvalid && s_tready;
  assign pixel       = s_tdata[rce_pkg::PIXEL_W-1:0];
  assign col_is_last = (col == w_last);
  assign row_is_last = (row == h_last);
  assign col_nz      = (col != '0);
  assign row_nz      = (row != '0);

  always_comb begin
    in_mask = '0;
    in_mask[rce_pkg::RES_GRAD]    = row_nz && col_nz;
    in_mask[rce_pkg::RES_COL_END] = row_nz && col_is_last;
    in_mask[rce_pkg::RES_ROW_END] = row_is_last && col_nz;
    in_mask[rce_pkg::RES_FRM_END] = row_is_last && col_is_last;
  end

  // Advance the raster position; a write to either image register restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_write && cfg_hit) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (col_is_last) begin
        col <= '0;
        row <= row_is_last ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Read the pixel above and overwrite it with the current one in the same cycle
  rce_ram #(
    .WIDTH (rce_pkg::PIXEL_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (col),
    .wdata (pixel),
    .re    (in_fire),
    .raddr (col),
    .rdata (above)
  );

  // --------------------------------------------------------------------------
  // Result stage: one item; while the output is free, emits its pending results one per clock
  // --------------------------------------------------------------------------
  logic               b_valid;
  rce_pkg::res_mask_t b_mask;
  logic [rce_pkg::PIXEL_W-1:0] b_pixel;
  logic [COL_W-1:0]   b_col;
  logic [ROW_W-1:0]   b_row;
  logic [rce_pkg::PIXEL_W-1:0] left_pixel;
  logic [rce_pkg::PIXEL_W-1:0] upper_left_pixel;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_pixel <= pixel;
      b_col   <= col;
      b_row   <= row;
    end
  end

  rce_pkg::res_mask_t sel;
  rce_pkg::res_mask_t rest;
  logic out_free;
  logic b_step;
  logic b_emit;
  logic b_done;

  // Lowest pending result goes next
  assign sel      = b_mask & (~b_mask + 1'b1);
  assign rest     = b_mask & ~sel;
  assign out_free = !m_tvalid || m_tready;
  assign b_step   = b_valid && ((b_mask == '0) || out_free);
  assign b_emit   = b_step && (b_mask != '0);
  assign b_done   = b_step && (rest == '0);
  assign s_tready = !b_valid || b_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_mask  <= '0;
    end else if (in_fire) begin
      b_valid <= 1'b1;
      b_mask  <= in_mask;
    end else if (b_done) begin
      b_valid <= 1'b0;
      b_mask  <= '0;
    end else if (b_step) begin
      b_mask  <= rest;
    end
  end

  // Shift the 2x2 window once the item has issued all of its results
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (b_done) begin
      left_pixel       <= b_pixel;
      upper_left_pixel <= above;
    end
  end

  // Gradient: |top-left - bottom-right| + |top-right - bottom-left|, saturated
  logic [rce_pkg::PIXEL_W-1:0] diff_main;
  logic [rce_pkg::PIXEL_W-1:0] diff_anti;
  logic [rce_pkg::PIXEL_W:0]   mag_sum;
  logic [rce_pkg::EDGE_W-1:0]  mag;

  assign diff_main = (upper_left_pixel > b_pixel) ? upper_left_pixel - b_pixel
                                                  : b_pixel - upper_left_pixel;
  assign diff_anti = (above > left_pixel) ? above - left_pixel : left_pixel - above;
  assign mag_sum   = {1'b0, diff_main} + {1'b0, diff_anti};
  assign mag       = mag_sum[rce_pkg::PIXEL_W] ? rce_pkg::EDGE_MAX
                                               : mag_sum[rce_pkg::EDGE_W-1:0];

  // Tag of the selected result
  logic [COL_W-1:0] res_col;
  logic [ROW_W-1:0] res_row;
  logic [rce_pkg::EDGE_W-1:0] res_edge;
  logic             res_frame_end;

  always_comb begin
    res_edge      = '0;
    res_row       = b_row;
    res_col       = b_col;
    res_frame_end = 1'b0;
    if (sel[rce_pkg::RES_GRAD]) begin
      res_edge = mag;
      res_row  = b_row - 1'b1;
      res_col  = b_col - 1'b1;
    end else if (sel[rce_pkg::RES_COL_END]) begin
      res_row  = b_row - 1'b1;
    end else if (sel[rce_pkg::RES_ROW_END]) begin
      res_col  = b_col - 1'b1;
    end else begin
      res_frame_end = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_emit) begin
      m_tdata <= {1'b0,
                  rce_pkg::OUT_COL_W'(res_col),
                  rce_pkg::OUT_ROW_W'(res_row),
                  res_edge};
      m_tlast <= (rest == '0);
      m_tuser <= res_frame_end;
    end
  end

endmodule

@@ rtl/core/rce_ram.sv @@
// ----------------------------------------------------------------------------
// rce_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module rce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/rce_checker.sv @@
// ----------------------------------------------------------------------------
// rce_checker
// Port-level checks for the Roberts cross edge filter, bound to the top level.
// ----------------------------------------------------------------------------
module rce_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [rce_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic                            m_tlast,
  input logic                            m_tuser
);

  // A word left waiting holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("output word changed while stalled");

  // The frame end result is the last one of its pixel
  a_frame_end_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame end without last");

  // The frame end result sits in the last row and column: always zero
  a_frame_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[rce_pkg::EDGE_W-1:0] == '0)
    else $error("frame end result not zero");

  // Nothing leaves in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind roberts_cross_edge_filter rce_checker u_rce_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
